### hw/rtl/rfc_pkg.sv
// rfc_pkg: shared types, codes and constants of the reply frame checker
// used by rfc_cap_table, rfc_seq and reply_frame_checker_unit
package rfc_pkg;

  localparam int unsigned MaxParamsDefault = 8;
  // param_index is 3 bits wide, so at most this many capacities are storable
  localparam int unsigned CapSlotsMax = 8;

  // item kinds
  localparam logic [1:0] CMD_SET_CAP = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_RX_BYTE = 2'd2;

  // length modes
  localparam logic [1:0] MODE_MULTI8 = 2'd0;
  localparam logic [1:0] MODE_SINGLE8 = 2'd1;
  localparam logic [1:0] MODE_SINGLE16 = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  // result kinds
  localparam logic [1:0] RES_DATA = 2'd0;
  localparam logic [1:0] RES_LENGTH = 2'd1;
  localparam logic [1:0] RES_FINISH = 2'd2;

  // frame status codes
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_BAD_CMD = 3'd2;
  localparam logic [2:0] ST_BAD_COUNT = 3'd3;
  localparam logic [2:0] ST_UNSUP_COUNT = 3'd4;
  localparam logic [2:0] ST_BAD_END = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_START_MARKER = 2'd0;
  localparam logic [1:0] CFG_END_MARKER = 2'd1;
  localparam logic [1:0] CFG_RSP_MASK = 2'd2;

  localparam logic [7:0] StartMarkerReset = 8'd224;
  localparam logic [7:0] EndMarkerReset = 8'd238;
  localparam logic [7:0] RspMaskReset = 8'd128;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START  = 4'd1,
    PH_CMD    = 4'd2,
    PH_COUNT  = 4'd3,
    PH_LEN    = 4'd4,
    PH_LEN_HI = 4'd5,
    PH_LEN_LO = 4'd6,
    PH_DATA   = 4'd7,
    PH_END    = 4'd8
  } phase_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  param_index;
    logic [15:0] capacity;
    logic [7:0]  expected_command;
    logic [7:0]  expected_count;
    logic [1:0]  length_mode;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  param_number;
    logic [15:0] byte_index;
    logic [7:0]  out_byte;
    logic [15:0] kept_length;
    logic [2:0]  status;
  } result_t;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
    logic [7:0] rsp_mask;
  } cfg_t;

endpackage

### hw/rtl/rfc_cap_table.sv
// rfc_cap_table: per-parameter capacity registers, one write and one read port
// depends on rfc_pkg
module rfc_cap_table #(
  parameter int unsigned MAX_PARAMS = rfc_pkg::MaxParamsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_en_i,
  input  logic [2:0]  wr_idx_i,
  input  logic [15:0] wr_cap_i,
  input  logic [7:0]  rd_param_i,
  output logic [15:0] rd_cap_o
);

  localparam int unsigned CapDepth =
    (MAX_PARAMS < rfc_pkg::CapSlotsMax) ? MAX_PARAMS : rfc_pkg::CapSlotsMax;
  localparam int unsigned CapIdxW = (CapDepth > 1) ? $clog2(CapDepth) : 1;
  localparam int unsigned CapSlots = 2 ** CapIdxW;

  logic [15:0] cap_q [CapSlots];
  logic        wr_hit;
  logic        rd_hit;

  assign wr_hit = wr_en_i && ({29'd0, wr_idx_i} < 32'(CapDepth));
  assign rd_hit = {24'd0, rd_param_i} < 32'(CapDepth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CapSlots; i++) begin
        cap_q[i] <= '0;
      end
    end else if (wr_hit) begin
      cap_q[wr_idx_i[CapIdxW-1:0]] <= wr_cap_i;
    end
  end

  // parameters past the table have capacity zero
  assign rd_cap_o = rd_hit ? cap_q[rd_param_i[CapIdxW-1:0]] : 16'd0;

endmodule

### hw/rtl/rfc_seq.sv
// rfc_seq: frame sequencer, phase and arming state plus per-item decision logic
// depends on rfc_pkg; capacity comes from rfc_cap_table
module rfc_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  rfc_pkg::item_t   item_i,
  input  rfc_pkg::cfg_t    cfg_i,
  output logic [7:0]       cap_param_o,
  input  logic [15:0]      cap_i,
  output logic             res_valid_o,
  output rfc_pkg::result_t res_o
);

  rfc_pkg::phase_e phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  count_q, count_d;
  logic [1:0]  mode_q, mode_d;
  logic [7:0]  param_q, param_d;
  logic [15:0] ann_q, ann_d;
  logic [15:0] seen_q, seen_d;

  logic [7:0]  param_inc;
  logic        single_mode;
  logic [15:0] len_lo;
  logic [15:0] seen_inc;
  logic [15:0] kept;

  assign cap_param_o = param_q;
  assign param_inc   = param_q + 8'd1;
  assign single_mode = (mode_q == rfc_pkg::MODE_SINGLE8) || (mode_q == rfc_pkg::MODE_SINGLE16);
  assign len_lo      = ann_q | {8'd0, item_i.rx_byte};
  assign seen_inc    = seen_q + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rfc_pkg::PH_IDLE;
      cmd_q   <= '0;
      count_q <= '0;
      mode_q  <= '0;
      param_q <= '0;
      ann_q   <= '0;
      seen_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      count_q <= count_d;
      mode_q  <= mode_d;
      param_q <= param_d;
      ann_q   <= ann_d;
      seen_q  <= seen_d;
    end
  end

  always_comb begin
    logic [15:0] ann_v;
    phase_d = phase_q;
    cmd_d   = cmd_q;
    count_d = count_q;
    mode_d  = mode_q;
    param_d = param_q;
    ann_d   = ann_q;
    seen_d  = seen_q;
    res_valid_o = 1'b0;
    res_o = '0;
    ann_v = ann_q;
    kept  = 16'd0;

    if (fire_i) begin
      unique case (item_i.cmd)
        rfc_pkg::CMD_START: begin
          cmd_d   = item_i.expected_command;
          count_d = item_i.expected_count;
          mode_d  = (item_i.length_mode == rfc_pkg::MODE_RESERVED) ? rfc_pkg::MODE_MULTI8
                                                                   : item_i.length_mode;
          param_d = '0;
          ann_d   = '0;
          seen_d  = '0;
          phase_d = rfc_pkg::PH_START;
        end
        rfc_pkg::CMD_RX_BYTE: begin
          unique case (phase_q)
            rfc_pkg::PH_START: begin
              if (item_i.rx_byte != cfg_i.start_marker) begin
                phase_d = rfc_pkg::PH_IDLE;
                res_valid_o = 1'b1;
                res_o.result_kind = rfc_pkg::RES_FINISH;
                res_o.status = rfc_pkg::ST_BAD_START;
              end else begin
                phase_d = rfc_pkg::PH_CMD;
              end
            end
            rfc_pkg::PH_CMD: begin
              if (item_i.rx_byte != (cmd_q | cfg_i.rsp_mask)) begin
                phase_d = rfc_pkg::PH_IDLE;
                res_valid_o = 1'b1;
                res_o.result_kind = rfc_pkg::RES_FINISH;
                res_o.status = rfc_pkg::ST_BAD_CMD;
              end else begin
                phase_d = rfc_pkg::PH_COUNT;
              end
            end
            rfc_pkg::PH_COUNT: begin
              param_d = '0;
              priority if (item_i.rx_byte != count_q) begin
                phase_d = rfc_pkg::PH_IDLE;
                res_valid_o = 1'b1;
                res_o.result_kind = rfc_pkg::RES_FINISH;
                res_o.status = rfc_pkg::ST_BAD_COUNT;
              end else if (count_q == 8'd0) begin
                phase_d = rfc_pkg::PH_END;
              end else if (mode_q == rfc_pkg::MODE_MULTI8) begin
                phase_d = rfc_pkg::PH_LEN;
              end else if (count_q != 8'd1) begin
                phase_d = rfc_pkg::PH_IDLE;
                res_valid_o = 1'b1;
                res_o.result_kind = rfc_pkg::RES_FINISH;
                res_o.status = rfc_pkg::ST_UNSUP_COUNT;
              end else begin
                phase_d = (mode_q == rfc_pkg::MODE_SINGLE16) ? rfc_pkg::PH_LEN_HI
                                                              : rfc_pkg::PH_LEN;
              end
            end
            rfc_pkg::PH_LEN_HI: begin
              ann_d   = {item_i.rx_byte, 8'd0};
              phase_d = rfc_pkg::PH_LEN_LO;
            end
            rfc_pkg::PH_LEN, rfc_pkg::PH_LEN_LO: begin
              // settle the length and report min(announced, capacity)
              ann_v = (phase_q == rfc_pkg::PH_LEN) ? {8'd0, item_i.rx_byte} : len_lo;
              ann_d = ann_v;
              kept = (ann_v < cap_i) ? ann_v : cap_i;
              seen_d = '0;
              if (ann_v == 16'd0) begin
                param_d = param_inc;
                phase_d = ((param_inc >= count_q) || single_mode) ? rfc_pkg::PH_END
                                                                  : rfc_pkg::PH_LEN;
              end else begin
                phase_d = rfc_pkg::PH_DATA;
              end
              res_valid_o = 1'b1;
              res_o.result_kind  = rfc_pkg::RES_LENGTH;
              res_o.param_number = param_q;
              res_o.kept_length  = kept;
            end
            rfc_pkg::PH_DATA: begin
              // bytes past the capacity are consumed and dropped
              if (seen_q < cap_i) begin
                res_valid_o = 1'b1;
                res_o.result_kind  = rfc_pkg::RES_DATA;
                res_o.param_number = param_q;
                res_o.byte_index   = seen_q;
                res_o.out_byte     = item_i.rx_byte;
              end
              seen_d = seen_inc;
              if (seen_inc >= ann_q) begin
                param_d = param_inc;
                phase_d = ((param_inc >= count_q) || single_mode) ? rfc_pkg::PH_END
                                                                  : rfc_pkg::PH_LEN;
              end
            end
            rfc_pkg::PH_END: begin
              phase_d = rfc_pkg::PH_IDLE;
              res_valid_o = 1'b1;
              res_o.result_kind = rfc_pkg::RES_FINISH;
              res_o.status = (item_i.rx_byte == cfg_i.end_marker) ? rfc_pkg::ST_OK
                                                                  : rfc_pkg::ST_BAD_END;
            end
            default: begin
              // byte while idle is ignored
            end
          endcase
        end
        default: begin
          // set-capacity goes to the table, kind three is ignored
        end
      endcase
    end
  end

endmodule

### hw/rtl/reply_frame_checker_unit.sv
// reply_frame_checker_unit: top level with input register, result register and config
// depends on rfc_pkg, rfc_cap_table and rfc_seq
//
//  channel  direction  handshake                  payload
//  in       sink       in_valid_i / in_ready_o    cmd_i .. rx_byte_i
//  out      source     out_valid_o / out_ready_i  result_kind_o .. status_o
//  cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one item per cycle sustained while the result register is not stalled; an item sits in
// the input register, is decided by the sequencer logic and its result is registered in
// the result register, which drives out_valid_o
// the input register advances whenever the result register is empty or being taken
// reset clears the valid flags, config, sequencer state and the capacity table at once;
// the input and result payload registers are not reset; no clearing pass; cfg_ready_o is always high
module reply_frame_checker_unit #(
  parameter int unsigned MAX_PARAMS = rfc_pkg::MaxParamsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [2:0]  param_index_i,
  input  logic [15:0] capacity_i,
  input  logic [7:0]  expected_command_i,
  input  logic [7:0]  expected_count_i,
  input  logic [1:0]  length_mode_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  param_number_o,
  output logic [15:0] byte_index_o,
  output logic [7:0]  out_byte_o,
  output logic [15:0] kept_length_o,
  output logic [2:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  rfc_pkg::cfg_t    cfg_q;
  rfc_pkg::item_t   item_q;
  logic             item_valid_q;
  rfc_pkg::result_t out_q;
  logic             out_valid_q;

  logic             adv;
  logic             res_valid;
  rfc_pkg::result_t res;
  logic [7:0]       cap_param;
  logic [15:0]      cap;
  logic             cap_wr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= rfc_pkg::StartMarkerReset;
      cfg_q.end_marker   <= rfc_pkg::EndMarkerReset;
      cfg_q.rsp_mask     <= rfc_pkg::RspMaskReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rfc_pkg::CFG_START_MARKER: cfg_q.start_marker <= cfg_data_i;
        rfc_pkg::CFG_END_MARKER:   cfg_q.end_marker   <= cfg_data_i;
        rfc_pkg::CFG_RSP_MASK:     cfg_q.rsp_mask     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign adv        = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.cmd              <= cmd_i;
      item_q.param_index      <= param_index_i;
      item_q.capacity         <= capacity_i;
      item_q.expected_command <= expected_command_i;
      item_q.expected_count   <= expected_count_i;
      item_q.length_mode      <= length_mode_i;
      item_q.rx_byte          <= rx_byte_i;
    end
  end

  assign cap_wr = adv && (item_q.cmd == rfc_pkg::CMD_SET_CAP);

  rfc_cap_table #(
    .MAX_PARAMS(MAX_PARAMS)
  ) u_cap_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cap_wr),
    .wr_idx_i  (item_q.param_index),
    .wr_cap_i  (item_q.capacity),
    .rd_param_i(cap_param),
    .rd_cap_o  (cap)
  );

  rfc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (adv),
    .item_i     (item_q),
    .cfg_i      (cfg_q),
    .cap_param_o(cap_param),
    .cap_i      (cap),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_q.result_kind;
  assign param_number_o = out_q.param_number;
  assign byte_index_o   = out_q.byte_index;
  assign out_byte_o     = out_q.out_byte;
  assign kept_length_o  = out_q.kept_length;
  assign status_o       = out_q.status;

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !adv)
    else $error("input stage advanced over a stalled result");

  // back pressure only comes from a held item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (item_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked item");

  // only frame-finished results carry a status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.result_kind != rfc_pkg::RES_FINISH))
      |-> (out_q.status == rfc_pkg::ST_OK))
    else $error("status set on a data or length result");

  // set-capacity and start items never produce a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && ((item_q.cmd == rfc_pkg::CMD_SET_CAP) || (item_q.cmd == rfc_pkg::CMD_START)))
      |=> ($stable(out_valid_q) || $fell(out_valid_q)))
    else $error("result produced by a non-byte item");

endmodule
